// ===== design/kws_pkg.sv =====
// Shared types, constants and lookup functions for the keyboard wavetable synthesizer.
// No dependencies; every other design file imports this package.
`default_nettype none

package kws_pkg;

    localparam int TABLE_LENGTH_DEF = 48000;
    localparam int VOICES_DEF       = 8;
    localparam int SAMPLE_WIDTH_DEF = 24;

    localparam int CODE_W   = 8;
    localparam int VOL_W    = 4;
    localparam int OUT_W    = 31;
    localparam int VCODE_W  = 3;
    localparam int RATE_W   = 9;
    localparam int SERIES_W = 3;

    localparam logic [CODE_W-1:0] CODE_BREAK    = 8'hF0;
    localparam logic [CODE_W-1:0] CODE_VOL_UP   = 8'h49;
    localparam logic [CODE_W-1:0] CODE_VOL_DOWN = 8'h41;

    localparam logic [VOL_W-1:0] VOLUME_RESET = 4'd1;
    localparam logic [VOL_W-1:0] LIMIT_RESET  = 4'd10;

    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [SERIES_W-1:0] SERIES_TERMS = 3'd6;

    typedef struct packed {
        logic key_upd;
        logic acc_clr;
        logic rd_en;
        logic out_load;
    } kws_cmd_t;

    typedef struct packed {
        logic fill_done;
        logic rd_last;
        logic out_free;
    } kws_status_t;

    function automatic logic [CODE_W-1:0] voice_code(input logic [VCODE_W-1:0] v);
        logic [CODE_W-1:0] c;
        case (v)
            3'd0:    c = 8'h1C;
            3'd1:    c = 8'h1B;
            3'd2:    c = 8'h23;
            3'd3:    c = 8'h2B;
            3'd4:    c = 8'h3B;
            3'd5:    c = 8'h42;
            3'd6:    c = 8'h4B;
            default: c = 8'h4C;
        endcase
        return c;
    endfunction

    function automatic logic [RATE_W-1:0] voice_rate(input logic [VCODE_W-1:0] v);
        logic [RATE_W-1:0] r;
        case (v)
            3'd0:    r = 9'd130;
            3'd1:    r = 9'd146;
            3'd2:    r = 9'd164;
            3'd3:    r = 9'd174;
            3'd4:    r = 9'd195;
            3'd5:    r = 9'd220;
            3'd6:    r = 9'd246;
            default: r = 9'd261;
        endcase
        return r;
    endfunction

    // Taylor divisor 2k(2k+1) for term k
    function automatic logic [7:0] series_div(input logic [SERIES_W-1:0] k);
        logic [7:0] d;
        case (k)
            3'd1:    d = 8'd6;
            3'd2:    d = 8'd20;
            3'd3:    d = 8'd42;
            3'd4:    d = 8'd72;
            3'd5:    d = 8'd110;
            default: d = 8'd156;
        endcase
        return d;
    endfunction

    // floor(2^32 / series_div(k))
    function automatic logic [31:0] series_recip(input logic [SERIES_W-1:0] k);
        logic [31:0] m;
        case (k)
            3'd1:    m = 32'd715827882;
            3'd2:    m = 32'd214748364;
            3'd3:    m = 32'd102261126;
            3'd4:    m = 32'd59652323;
            3'd5:    m = 32'd39045157;
            default: m = 32'd27531841;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== design/kws_sine_gen.sv =====
// Sine table generator: evaluates one table entry at a time on a shared 32x32 multiplier.
// Depends on kws_pkg for the series constants.
`default_nettype none

module kws_sine_gen #(
    parameter int TABLE_LENGTH = kws_pkg::TABLE_LENGTH_DEF,
    parameter int SAMPLE_WIDTH = kws_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    output logic                                         wr_en,
    output logic [$clog2(TABLE_LENGTH)-1:0]              wr_addr,
    output logic signed [SAMPLE_WIDTH-1:0]               wr_data,
    output logic                                         done
);
    import kws_pkg::*;

    localparam int AW = $clog2(TABLE_LENGTH);
    localparam logic [31:0] PH_STEP = 32'(64'h1_0000_0000 / 64'(TABLE_LENGTH));
    localparam logic [AW-1:0] PH_REM = AW'(64'h1_0000_0000 % 64'(TABLE_LENGTH));
    localparam logic [SAMPLE_WIDTH-2:0] AMP = '1;
    localparam logic [63:0] ROUND_HALF = 64'h2000_0000;

    localparam logic [3:0] G_MX    = 4'd0;
    localparam logic [3:0] G_MX2   = 4'd1;
    localparam logic [3:0] G_X2    = 4'd2;
    localparam logic [3:0] G_TERM  = 4'd3;
    localparam logic [3:0] G_RECIP = 4'd4;
    localparam logic [3:0] G_BACK  = 4'd5;
    localparam logic [3:0] G_FIX   = 4'd6;
    localparam logic [3:0] G_AMP   = 4'd7;
    localparam logic [3:0] G_WRITE = 4'd8;
    localparam logic [3:0] G_DONE  = 4'd9;

    logic [3:0]          state_reg, state_next;
    logic [SERIES_W-1:0] k_reg, k_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [31:0]         ph_reg, ph_next;
    logic [AW-1:0]       rem_reg, rem_next;
    logic                done_reg, done_next;

    logic [63:0]         prod_reg, prod_next;
    logic [31:0]         term_reg, term_next;
    logic [31:0]         x2_reg, x2_next;
    logic [31:0]         n_reg, n_next;
    logic [31:0]         q_reg, q_next;
    logic signed [33:0]  sum_reg, sum_next;

    logic [1:0]          quad;
    logic [30:0]         r_eff;
    logic [31:0]         mul_a, mul_b;
    logic [31:0]         fix_rem;
    logic [7:0]          div_k;
    logic [63:0]         rounded;
    logic [33:0]         mag_full;
    logic [SAMPLE_WIDTH-2:0] mag;
    logic [AW:0]         rem_sum;

    always_comb
    begin
        quad  = ph_reg[31:30];
        r_eff = quad[0] ? (31'h4000_0000 - {1'b0, ph_reg[29:0]}) : {1'b0, ph_reg[29:0]};
        div_k = series_div(k_reg);
        fix_rem = n_reg - prod_reg[31:0];
        rounded = prod_reg + ROUND_HALF;
        mag_full = rounded[63:30];
        mag = (mag_full > 34'(AMP)) ? AMP : mag_full[SAMPLE_WIDTH-2:0];
        rem_sum = {1'b0, rem_reg} + {1'b0, PH_REM};

        state_next = state_reg;
        k_next     = k_reg;
        idx_next   = idx_reg;
        ph_next    = ph_reg;
        rem_next   = rem_reg;
        done_next  = done_reg;
        term_next  = term_reg;
        x2_next    = x2_reg;
        n_next     = n_reg;
        q_next     = q_reg;
        sum_next   = sum_reg;
        mul_a      = '0;
        mul_b      = '0;

        case (state_reg)
            G_MX:
            begin
                mul_a      = {1'b0, r_eff};
                mul_b      = HALF_PI_Q30;
                state_next = G_MX2;
            end
            G_MX2:
            begin
                mul_a      = prod_reg[61:30];
                mul_b      = prod_reg[61:30];
                term_next  = prod_reg[61:30];
                sum_next   = $signed({2'b00, prod_reg[61:30]});
                k_next     = SERIES_W'(1);
                state_next = G_X2;
            end
            G_X2:
            begin
                x2_next    = prod_reg[61:30];
                mul_a      = term_reg;
                mul_b      = prod_reg[61:30];
                state_next = G_RECIP;
            end
            G_TERM:
            begin
                mul_a      = term_reg;
                mul_b      = x2_reg;
                state_next = G_RECIP;
            end
            G_RECIP:
            begin
                n_next     = prod_reg[61:30];
                mul_a      = prod_reg[61:30];
                mul_b      = series_recip(k_reg);
                state_next = G_BACK;
            end
            G_BACK:
            begin
                q_next     = prod_reg[63:32];
                mul_a      = prod_reg[63:32];
                mul_b      = 32'(div_k);
                state_next = G_FIX;
            end
            G_FIX:
            begin
                term_next = (fix_rem >= 32'(div_k)) ? q_reg + 32'd1 : q_reg;
                if (k_reg[0])
                begin
                    sum_next = sum_reg - $signed({2'b00, term_next});
                end
                else
                begin
                    sum_next = sum_reg + $signed({2'b00, term_next});
                end
                if (k_reg == SERIES_TERMS)
                begin
                    state_next = G_AMP;
                end
                else
                begin
                    k_next     = k_reg + SERIES_W'(1);
                    state_next = G_TERM;
                end
            end
            G_AMP:
            begin
                mul_a      = sum_reg[33] ? 32'd0 : sum_reg[31:0];
                mul_b      = 32'(AMP);
                state_next = G_WRITE;
            end
            G_WRITE:
            begin
                idx_next = idx_reg + AW'(1);
                if (rem_sum >= (AW + 1)'(TABLE_LENGTH))
                begin
                    rem_next = AW'(rem_sum - (AW + 1)'(TABLE_LENGTH));
                    ph_next  = ph_reg + PH_STEP + 32'd1;
                end
                else
                begin
                    rem_next = rem_sum[AW-1:0];
                    ph_next  = ph_reg + PH_STEP;
                end
                if ({1'b0, idx_reg} == (AW + 1)'(TABLE_LENGTH - 1))
                begin
                    done_next  = 1'b1;
                    state_next = G_DONE;
                end
                else
                begin
                    state_next = G_MX;
                end
            end
            G_DONE:
            begin
                state_next = G_DONE;
            end
            default:
            begin
                state_next = G_DONE;
            end
        endcase

        prod_next = 64'(mul_a) * 64'(mul_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= G_MX;
            k_reg     <= '0;
            idx_reg   <= '0;
            ph_reg    <= '0;
            rem_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            idx_reg   <= idx_next;
            ph_reg    <= ph_next;
            rem_reg   <= rem_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        term_reg <= term_next;
        x2_reg   <= x2_next;
        n_reg    <= n_next;
        q_reg    <= q_next;
        sum_reg  <= sum_next;
    end

    assign wr_en   = (state_reg == G_WRITE);
    assign wr_addr = idx_reg;
    assign wr_data = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    assign done    = done_reg;

    ap_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> done_reg)
        else $error("table generator left the done state");

    ap_fix_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == G_FIX) |-> (fix_rem < {23'd0, div_k, 1'b0}))
        else $error("reciprocal quotient off by more than one");

    ap_no_write_done: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !done_reg)
        else $error("table write after fill completed");

endmodule

`default_nettype wire

// ===== design/kws_dp.sv =====
// Datapath: key state, volume, per-voice phase accumulators, sine table memory and output register.
// Depends on kws_pkg and kws_sine_gen.
`default_nettype none

module kws_dp #(
    parameter int TABLE_LENGTH = kws_pkg::TABLE_LENGTH_DEF,
    parameter int VOICES       = kws_pkg::VOICES_DEF,
    parameter int SAMPLE_WIDTH = kws_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire kws_pkg::kws_cmd_t                  cmd,
    output kws_pkg::kws_status_t                    status,
    input  wire logic [kws_pkg::CODE_W-1:0]         scan_code,
    input  wire logic                               cfg_wr_en,
    input  wire logic [kws_pkg::VOL_W-1:0]          cfg_wr_data,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [kws_pkg::OUT_W-1:0]               sample
);
    import kws_pkg::*;

    localparam int AW     = $clog2(TABLE_LENGTH);
    localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int ACC_W  = SAMPLE_WIDTH + 3;

    logic signed [SAMPLE_WIDTH-1:0] rom_mem [TABLE_LENGTH];

    logic                      gen_wr_en;
    logic [AW-1:0]             gen_wr_addr;
    logic signed [SAMPLE_WIDTH-1:0] gen_wr_data;
    logic                      gen_done;

    logic [VOICES-1:0]         held_reg, held_next;
    logic                      brk_reg, brk_next;
    logic [VOL_W-1:0]          volume_reg, volume_next;
    logic [VOL_W-1:0]          limit_reg;
    logic [AW-1:0]             phase_reg [VOICES];
    logic [VIDX_W-1:0]         vcnt_reg;
    logic                      acc_en_reg;
    logic                      held_bit_reg;
    logic signed [SAMPLE_WIDTH-1:0] rd_data_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic                      out_valid_reg;
    logic [OUT_W-1:0]          sample_reg;

    logic [VOICES-1:0]         hit_vec;
    logic [AW:0]               phase_sum;
    logic [AW-1:0]             phase_adv;
    logic signed [OUT_W-1:0]   acc_ext;
    logic signed [OUT_W-1:0]   vol_ext;

    kws_sine_gen #(
        .TABLE_LENGTH (TABLE_LENGTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_sine_gen (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (gen_wr_en),
        .wr_addr (gen_wr_addr),
        .wr_data (gen_wr_data),
        .done    (gen_done)
    );

    always_ff @(posedge clk)
    begin
        if (gen_wr_en)
        begin
            rom_mem[gen_wr_addr] <= gen_wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= rom_mem[phase_reg[vcnt_reg]];
        end
    end

    always_comb
    begin
        for (int v = 0; v < VOICES; v++)
        begin
            hit_vec[v] = (scan_code == voice_code(VCODE_W'(v)));
        end

        held_next   = held_reg;
        brk_next    = brk_reg;
        volume_next = volume_reg;
        if (cmd.key_upd)
        begin
            if (|hit_vec)
            begin
                if (brk_reg)
                begin
                    held_next = held_reg & ~hit_vec;
                    brk_next  = 1'b0;
                end
                else
                begin
                    held_next = held_reg | hit_vec;
                end
            end
            else if (scan_code == CODE_VOL_UP)
            begin
                if (brk_reg)
                begin
                    if (volume_reg < limit_reg)
                    begin
                        volume_next = volume_reg + VOL_W'(1);
                    end
                    brk_next = 1'b0;
                end
            end
            else if (scan_code == CODE_VOL_DOWN)
            begin
                if (brk_reg)
                begin
                    if (volume_reg != '0)
                    begin
                        volume_next = volume_reg - VOL_W'(1);
                    end
                    brk_next = 1'b0;
                end
            end
            else if (scan_code == CODE_BREAK)
            begin
                brk_next = 1'b1;
            end
            else
            begin
                brk_next = 1'b0;
            end
        end

        phase_sum = {1'b0, phase_reg[vcnt_reg]}
                  + (AW + 1)'(voice_rate(VCODE_W'(vcnt_reg)));
        if (phase_sum >= (AW + 1)'(TABLE_LENGTH))
        begin
            phase_adv = AW'(phase_sum - (AW + 1)'(TABLE_LENGTH));
        end
        else
        begin
            phase_adv = phase_sum[AW-1:0];
        end

        acc_ext = OUT_W'(acc_reg);
        vol_ext = $signed({{(OUT_W - VOL_W){1'b0}}, volume_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            brk_reg       <= 1'b0;
            volume_reg    <= VOLUME_RESET;
            limit_reg     <= LIMIT_RESET;
            vcnt_reg      <= '0;
            acc_en_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int v = 0; v < VOICES; v++)
            begin
                phase_reg[v] <= '0;
            end
        end
        else
        begin
            held_reg   <= held_next;
            brk_reg    <= brk_next;
            volume_reg <= volume_next;
            acc_en_reg <= cmd.rd_en;
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            if (cmd.acc_clr)
            begin
                vcnt_reg <= '0;
            end
            else if (cmd.rd_en)
            begin
                vcnt_reg            <= vcnt_reg + VIDX_W'(1);
                phase_reg[vcnt_reg] <= phase_adv;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            held_bit_reg <= held_reg[vcnt_reg];
        end
        if (cmd.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (acc_en_reg && held_bit_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(rd_data_reg);
        end
        if (cmd.out_load)
        begin
            sample_reg <= OUT_W'(acc_ext * vol_ext);
        end
    end

    assign status.fill_done = gen_done;
    assign status.rd_last   = ({1'b0, vcnt_reg} == (VIDX_W + 1)'(VOICES - 1));
    assign status.out_free  = !out_valid_reg || !out_stall;
    assign out_valid        = out_valid_reg;
    assign sample           = sample_reg;

    ap_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, phase_reg[0]} < (AW + 1)'(TABLE_LENGTH))
        else $error("voice phase out of table range");

    ap_keys_stable: assert property (@(posedge clk) disable iff (!rst_n)
        acc_en_reg |-> $stable(held_reg) && $stable(volume_reg))
        else $error("key state changed during accumulation");

    ap_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("loaded sample not presented");

endmodule

`default_nettype wire

// ===== design/kws_ctrl.sv =====
// Controller: sequences table fill wait, key updates and the per-tick voice sweep.
// Depends on kws_pkg for the command and status structs.
`default_nettype none

module kws_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  req_type,
    input  wire kws_pkg::kws_status_t  status,
    output kws_pkg::kws_cmd_t          cmd
);
    import kws_pkg::*;

    localparam logic [2:0] C_FILL  = 3'd0;
    localparam logic [2:0] C_IDLE  = 3'd1;
    localparam logic [2:0] C_READ  = 3'd2;
    localparam logic [2:0] C_DRAIN = 3'd3;
    localparam logic [2:0] C_OUT   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       take;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        take         = in_valid && (state_reg == C_IDLE);
        case (state_reg)
            C_FILL:
            begin
                if (status.fill_done)
                begin
                    state_next = C_IDLE;
                end
            end
            C_IDLE:
            begin
                if (take)
                begin
                    if (req_type)
                    begin
                        cmd.acc_clr = 1'b1;
                        state_next  = C_READ;
                    end
                    else
                    begin
                        cmd.key_upd = 1'b1;
                    end
                end
            end
            C_READ:
            begin
                cmd.rd_en = 1'b1;
                if (status.rd_last)
                begin
                    state_next = C_DRAIN;
                end
            end
            C_DRAIN:
            begin
                state_next = C_OUT;
            end
            C_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_FILL;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != C_IDLE);

    ap_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && req_type) |=> (state_reg == C_READ))
        else $error("tick transfer did not start the voice sweep");

    ap_fill_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        !status.fill_done |-> in_stall)
        else $error("input taken before table fill completed");

    ap_single_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.key_upd, cmd.acc_clr, cmd.rd_en, cmd.out_load}))
        else $error("conflicting datapath commands");

endmodule

`default_nettype wire

// ===== design/keyboard_wavetable_synth.sv =====
// Top level of the keyboard wavetable synthesizer; depends on kws_pkg, kws_ctrl and kws_dp.
// Scan-code transfer: no result. Tick transfer: one sine table read per voice, and the sum
// times volume is loaded once the output is free; no new item is taken before that load.
// Reset (async, active low) clears keys, prefix and phases, sets volume 1 and limit 10, then
// fills the sine table, one entry per series evaluation on the shared 32x32 multiplier;
// no item is taken until the fill completes.
`default_nettype none

module keyboard_wavetable_synth #(
    parameter int TABLE_LENGTH = kws_pkg::TABLE_LENGTH_DEF,
    parameter int VOICES       = kws_pkg::VOICES_DEF,
    parameter int SAMPLE_WIDTH = kws_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           req_type,
    input  wire logic [kws_pkg::CODE_W-1:0]     scan_code,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [kws_pkg::OUT_W-1:0]           sample,
    input  wire logic                           cfg_wr_en,
    input  wire logic [kws_pkg::VOL_W-1:0]      cfg_wr_data
);
    import kws_pkg::*;

    kws_cmd_t    cmd;
    kws_status_t status;

    kws_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .req_type (req_type),
        .status   (status),
        .cmd      (cmd)
    );

    kws_dp #(
        .TABLE_LENGTH (TABLE_LENGTH),
        .VOICES       (VOICES),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .scan_code   (scan_code),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sample      (sample)
    );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for keyboard_wavetable_synth: scan-code and tick transfers with
// random idling on both channels, every sample checked against an in-bench synth predictor
// or a directed expected value. Depends on kws_pkg and the design files only.
`timescale 1ns / 1ps

module tb;

    localparam int TABLE_LEN = kws_pkg::TABLE_LENGTH_DEF;
    localparam int SW        = kws_pkg::SAMPLE_WIDTH_DEF;
    localparam int OW        = kws_pkg::OUT_W;
    localparam int SETTLE    = 2 * (kws_pkg::VOICES_DEF + 3);

    localparam logic REQ_SCAN = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic [7:0] KEY_BREAK = kws_pkg::CODE_BREAK;
    localparam logic [7:0] KEY_UP    = kws_pkg::CODE_VOL_UP;
    localparam logic [7:0] KEY_DOWN  = kws_pkg::CODE_VOL_DOWN;
    localparam logic [7:0] KEY_NONE  = 8'h00;
    localparam logic [7:0] KEY_FULL  = 8'hFF;

    localparam logic [7:0] NOTE_CODE [8] = '{8'h1C, 8'h1B, 8'h23, 8'h2B,
                                            8'h3B, 8'h42, 8'h4B, 8'h4C};
    localparam int unsigned NOTE_RATE [8] = '{130, 146, 164, 174, 195, 220, 246, 261};

    typedef struct packed {
        logic          rt;
        logic [7:0]    code;
        logic          typed;
        logic [OW-1:0] value;
    } stim_row_t;

    localparam int DIR_ROWS = 31;
    localparam stim_row_t DIRECTED [DIR_ROWS] = '{
        '{REQ_TICK, KEY_NONE,     1'b1, 31'd0},
        '{REQ_SCAN, NOTE_CODE[0], 1'b0, 31'd0},
        '{REQ_SCAN, KEY_BREAK,    1'b0, 31'd0},
        '{REQ_SCAN, NOTE_CODE[0], 1'b0, 31'd0},
        '{REQ_TICK, KEY_FULL,     1'b1, 31'd0},
        '{REQ_SCAN, NOTE_CODE[0], 1'b0, 31'd0},
        '{REQ_SCAN, NOTE_CODE[1], 1'b0, 31'd0},
        '{REQ_SCAN, NOTE_CODE[2], 1'b0, 31'd0},
        '{REQ_SCAN, NOTE_CODE[3], 1'b0, 31'd0},
        '{REQ_SCAN, NOTE_CODE[4], 1'b0, 31'd0},
        '{REQ_SCAN, NOTE_CODE[5], 1'b0, 31'd0},
        '{REQ_SCAN, NOTE_CODE[6], 1'b0, 31'd0},
        '{REQ_SCAN, NOTE_CODE[7], 1'b0, 31'd0},
        '{REQ_TICK, KEY_NONE,     1'b0, 31'd0},
        '{REQ_SCAN, KEY_UP,       1'b0, 31'd0},
        '{REQ_SCAN, KEY_DOWN,     1'b0, 31'd0},
        '{REQ_SCAN, KEY_BREAK,    1'b0, 31'd0},
        '{REQ_SCAN, KEY_BREAK,    1'b0, 31'd0},
        '{REQ_SCAN, KEY_UP,       1'b0, 31'd0},
        '{REQ_SCAN, KEY_BREAK,    1'b0, 31'd0},
        '{REQ_SCAN, KEY_DOWN,     1'b0, 31'd0},
        '{REQ_SCAN, KEY_BREAK,    1'b0, 31'd0},
        '{REQ_SCAN, KEY_DOWN,     1'b0, 31'd0},
        '{REQ_SCAN, KEY_BREAK,    1'b0, 31'd0},
        '{REQ_SCAN, KEY_DOWN,     1'b0, 31'd0},
        '{REQ_TICK, KEY_NONE,     1'b1, 31'd0},
        '{REQ_SCAN, KEY_BREAK,    1'b0, 31'd0},
        '{REQ_SCAN, KEY_FULL,     1'b0, 31'd0},
        '{REQ_SCAN, KEY_NONE,     1'b0, 31'd0},
        '{REQ_SCAN, KEY_BREAK,    1'b0, 31'd0},
        '{REQ_SCAN, KEY_UP,       1'b0, 31'd0}
    };

    localparam int PHASES = 5;
    localparam int PHASE_ITEMS = 225;

    logic          clk;
    logic          rst_n       = 1'b0;
    logic          in_valid    = 1'b0;
    logic          in_stall;
    logic          req_type    = REQ_SCAN;
    logic [7:0]    scan_code   = KEY_NONE;
    logic          out_valid;
    logic          out_stall   = 1'b0;
    logic [OW-1:0] sample;
    logic          cfg_wr_en   = 1'b0;
    logic [3:0]    cfg_wr_data = 4'd0;

    logic signed [SW-1:0] sine_table [TABLE_LEN];
    logic [OW-1:0] sample_q [$];

    logic [7:0]  held_keys;
    logic        break_armed;
    logic [3:0]  volume;
    logic [3:0]  volume_cap;
    int unsigned phase_t;

    bit calm = 1'b0;
    int mismatches = 0;
    int scans_sent = 0;
    int ticks_sent = 0;
    int samples_checked = 0;
    int loudest = 0;

    keyboard_wavetable_synth u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .scan_code   (scan_code),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sample      (sample),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(60_000_000);
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic signed [SW-1:0] sine_point(input int unsigned i);
        logic [63:0] ph, r, x, x2, term, mag, amp;
        longint acc;
        ph = ({32'd0, i} << 32) / 64'(TABLE_LEN);
        r = {34'd0, ph[29:0]};
        if (ph[30])
            r = (64'd1 << 30) - r;
        x = (r * 64'(kws_pkg::HALF_PI_Q30)) >> 30;
        x2 = (x * x) >> 30;
        term = x;
        acc = longint'(x);
        for (int k = 1; k <= 6; k++)
        begin
            term = (term * x2) >> 30;
            term = term / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
                acc -= longint'(term);
            else
                acc += longint'(term);
        end
        if (acc < 0)
            acc = 0;
        amp = (64'd1 << (SW - 1)) - 64'd1;
        mag = (64'(acc) * amp + (64'd1 << 29)) >> 30;
        if (mag > amp)
            mag = amp;
        return ph[31] ? -$signed(mag[SW-1:0]) : $signed(mag[SW-1:0]);
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatches++;
    endtask

    // Advance the synth state by one transfer; a tick yields one mixed sample.
    task automatic step_synth(input logic rt, input logic [7:0] code,
                              output bit made, output logic [OW-1:0] mixed);
        longint acc;
        bit noted;
        made = 1'b0;
        mixed = '0;
        noted = 1'b0;
        if (rt == REQ_TICK)
        begin
            acc = 0;
            for (int v = 0; v < 8; v++)
                if (held_keys[v])
                    acc += sine_table[(NOTE_RATE[v] * phase_t) % TABLE_LEN];
            acc = acc * longint'(volume);
            mixed = acc[OW-1:0];
            made = 1'b1;
            phase_t = (phase_t + 1 >= TABLE_LEN) ? 0 : phase_t + 1;
        end
        else
        begin
            for (int v = 0; v < 8; v++)
                if (!noted && code == NOTE_CODE[v])
                begin
                    noted = 1'b1;
                    if (break_armed)
                    begin
                        held_keys[v] = 1'b0;
                        break_armed = 1'b0;
                    end
                    else
                        held_keys[v] = 1'b1;
                end
            if (!noted)
            begin
                if (code == KEY_UP)
                begin
                    if (break_armed && volume < volume_cap)
                        volume = volume + 4'd1;
                    break_armed = 1'b0;
                end
                else if (code == KEY_DOWN)
                begin
                    if (break_armed && volume > 4'd0)
                        volume = volume - 4'd1;
                    break_armed = 1'b0;
                end
                else
                    break_armed = (code == KEY_BREAK);
            end
        end
    endtask

    task automatic send_item(input logic rt, input logic [7:0] code,
                             input logic typed, input logic [OW-1:0] value);
        bit made;
        logic [OW-1:0] mixed;
        in_valid <= 1'b1;
        req_type <= rt;
        scan_code <= code;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        step_synth(rt, code, made, mixed);
        if (made)
            sample_q.push_back(typed ? value : mixed);
        if (rt == REQ_TICK)
            ticks_sent++;
        else
            scans_sent++;
        if (volume > loudest)
            loudest = volume;
        if (!calm && $urandom_range(99) < 10)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
    endtask

    task automatic drain_samples();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sample_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_cap(input logic [3:0] cap);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        volume_cap = cap;
    endtask

    task automatic play_phase(input int up_pct, input int quota);
        int sent;
        int pick;
        logic [7:0] note;
        logic [7:0] vol_key;
        sent = 0;
        while (sent < quota)
        begin
            pick = $urandom_range(99);
            note = NOTE_CODE[$urandom_range(7)];
            vol_key = ($urandom_range(99) < up_pct) ? KEY_UP : KEY_DOWN;
            if (pick < 40)
            begin
                send_item(REQ_TICK, 8'($urandom_range(255)), 1'b0, '0);
                sent += 1;
            end
            else if (pick < 55)
            begin
                send_item(REQ_SCAN, note, 1'b0, '0);
                sent += 1;
            end
            else if (pick < 70)
            begin
                send_item(REQ_SCAN, KEY_BREAK, 1'b0, '0);
                send_item(REQ_SCAN, note, 1'b0, '0);
                sent += 2;
            end
            else if (pick < 82)
            begin
                send_item(REQ_SCAN, KEY_BREAK, 1'b0, '0);
                send_item(REQ_SCAN, vol_key, 1'b0, '0);
                sent += 2;
            end
            else if (pick < 86)
            begin
                send_item(REQ_SCAN, vol_key, 1'b0, '0);
                sent += 1;
            end
            else if (pick < 94)
            begin
                send_item(REQ_SCAN, 8'($urandom_range(255)), 1'b0, '0);
                sent += 1;
            end
            else
            begin
                send_item(REQ_SCAN, KEY_BREAK, 1'b0, '0);
                send_item(REQ_SCAN, 8'($urandom_range(255)), 1'b0, '0);
                sent += 2;
            end
        end
    endtask

    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(99) < 10);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (sample_q.size() == 0)
                report_mismatch($sformatf("unexpected sample %0d", $signed(sample)));
            else
            begin
                if (sample !== sample_q[0])
                    report_mismatch($sformatf("sample %0d, expected %0d",
                                              $signed(sample), $signed(sample_q[0])));
                void'(sample_q.pop_front());
                samples_checked++;
            end
        end
    end

    initial
    begin
        logic [3:0] caps [PHASES];
        int ups [PHASES];
        caps = '{4'd15, 4'd3, 4'd0, 4'($urandom_range(15)), 4'd10};
        ups = '{85, 50, 40, 50, 70};

        for (int i = 0; i < TABLE_LEN; i++)
            sine_table[i] = sine_point(i);
        held_keys = 8'd0;
        break_armed = 1'b0;
        volume = kws_pkg::VOLUME_RESET;
        volume_cap = kws_pkg::LIMIT_RESET;
        phase_t = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int n = 0; n < DIR_ROWS; n++)
            send_item(DIRECTED[n].rt, DIRECTED[n].code, DIRECTED[n].typed, DIRECTED[n].value);
        send_item(REQ_TICK, KEY_NONE, 1'b0, '0);

        for (int p = 0; p < PHASES; p++)
        begin
            drain_samples();
            write_cap(caps[p]);
            calm = (p == 1);
            play_phase(ups[p], PHASE_ITEMS);
        end
        calm = 1'b0;
        drain_samples();

        $display("Sent %0d scan codes and %0d ticks across %0d volume limits",
                 scans_sent, ticks_sent, PHASES + 1);
        $display("Checked %0d samples; volume reached %0d", samples_checked, loudest);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
